// File: rtl/vrnl_pkg.sv
// Shared constants, codes and types of the voxel radius neighbor labeller.
`default_nettype none

package vrnl_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 10;
    localparam int NUM_CELLS  = 8;
    localparam int BANK_DEPTH = MAX_POINTS / NUM_CELLS;
    localparam int CELL_AW    = $clog2(NUM_CELLS);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

    localparam int MODE_W     = 2;
    localparam int PITCH_W    = 16;
    localparam int THR_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int LEN_W      = COORD_BITS + PITCH_W;
    localparam int SQ_W       = 2 * LEN_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int LIMIT_W    = 2 * THR_W;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_Z   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd256;
    localparam logic [THR_W-1:0]   THR_RESET   = 24'd256;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } vrnl_point_t;

    // One word of a sweep: a query paired with one bank address.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [BANK_AW-1:0] addr;
        vrnl_point_t        q;
        logic               hit;
    } vrnl_word_t;

    typedef struct packed {
        logic               en;
        logic [CELL_AW-1:0] lane;
        logic [BANK_AW-1:0] addr;
        vrnl_point_t        data;
    } vrnl_wr_t;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch_x;
        logic [PITCH_W-1:0] pitch_y;
        logic [PITCH_W-1:0] pitch_z;
        logic [LIMIT_W-1:0] limit;
    } vrnl_geom_t;

endpackage

`default_nettype wire

// File: rtl/vrnl_if.sv
// Handshake channel interfaces: input items, results and configuration writes.
`default_nettype none

interface vrnl_item_if
    import vrnl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [MODE_W-1:0]     mode;
    logic [COORD_BITS-1:0] x_index;
    logic [COORD_BITS-1:0] y_index;
    logic [COORD_BITS-1:0] z_index;

    modport source (output valid, mode, x_index, y_index, z_index, input ready);
    modport sink (input valid, mode, x_index, y_index, z_index, output ready);
endinterface

interface vrnl_result_if
    import vrnl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  near_label;
    logic [COORD_BITS-1:0] echo_x;
    logic [COORD_BITS-1:0] echo_y;
    logic [COORD_BITS-1:0] echo_z;

    modport source (output valid, near_label, echo_x, echo_y, echo_z, input ready);
    modport sink (input valid, near_label, echo_x, echo_y, echo_z, output ready);
endinterface

interface vrnl_cfg_if
    import vrnl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/voxel_radius_neighbor_label_core.sv
// Top level of the voxel radius neighbor labeller: control, configuration and cell chain.
`default_nettype none

// A load word stores one reference voxel (loads past 1024 stored voxels are dropped) and
// a clear word empties the store. A query word sweeps the store: the references are
// spread over a chain of 8 cells, each holding a bank of 128 voxels, and one sweep word
// per bank address enters the chain each cycle, visits every cell in turn and gathers
// the near flag (one sweep word is sent even for an empty store). The sweep words pass
// from the issue register through the 8 cells, each with a 6-stage distance pipeline,
// into the final gather step, and the result is loaded into the output register.
// One query is swept at a time; the next load, clear or query word can be taken in the
// same cycle that the result appears, even while that result still waits in the output
// register, but a query cannot finish while an earlier result is still waiting. The near
// decision compares the sum of the squared, pitch-scaled axis distances with the squared
// threshold exactly, with no rounding. Configuration writes are taken at any time but
// must only be issued while the block is idle.

module voxel_radius_neighbor_label_core
    import vrnl_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    vrnl_cfg_if.sink    cfg,
    vrnl_item_if.sink   item,
    vrnl_result_if.source result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Configuration registers and the squared threshold derived from them.
    logic [PITCH_W-1:0] pitch_x_reg, pitch_y_reg, pitch_z_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [LIMIT_W-1:0] limit_reg;
    vrnl_geom_t         geom;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BANK_AW-1:0] addr_reg, addr_next;
    logic [BANK_AW-1:0] last_addr_reg, last_addr_next;
    logic               acc_reg, acc_next;
    vrnl_point_t        q_reg, q_next;
    vrnl_word_t         issue_reg, issue_next;
    vrnl_wr_t           wr;
    logic [COUNT_W-1:0] words;
    logic               item_acc;
    logic               out_load;

    logic               out_valid_reg;
    logic               out_label_reg;
    vrnl_point_t        out_q_reg;

    vrnl_word_t         chain [NUM_CELLS+1];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_x_reg <= PITCH_RESET;
            pitch_y_reg <= PITCH_RESET;
            pitch_z_reg <= PITCH_RESET;
            thr_reg     <= THR_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PITCH_X:   pitch_x_reg <= cfg.data[PITCH_W-1:0];
                REG_PITCH_Y:   pitch_y_reg <= cfg.data[PITCH_W-1:0];
                REG_PITCH_Z:   pitch_z_reg <= cfg.data[PITCH_W-1:0];
                REG_THRESHOLD: thr_reg     <= cfg.data[THR_W-1:0];
                default:       ;
            endcase
        end
    end

    // The limit follows thr_reg in the next cycle, long before a sweep needs it.
    always_ff @(posedge clk)
    begin
        limit_reg <= LIMIT_W'(thr_reg) * LIMIT_W'(thr_reg);
    end

    assign geom.pitch_x = pitch_x_reg;
    assign geom.pitch_y = pitch_y_reg;
    assign geom.pitch_z = pitch_z_reg;
    assign geom.limit   = limit_reg;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;

    // A load writes the next free slot; the low count bits pick the cell.
    assign wr.en     = item_acc && (item.mode == MODE_LOAD) &&
                       (count_reg < COUNT_W'(MAX_POINTS));
    assign wr.lane   = count_reg[CELL_AW-1:0];
    assign wr.addr   = count_reg[CELL_AW+BANK_AW-1:CELL_AW];
    assign wr.data.x = item.x_index;
    assign wr.data.y = item.y_index;
    assign wr.data.z = item.z_index;

    // Number of bank addresses that hold at least one stored voxel.
    assign words = (count_reg + COUNT_W'(NUM_CELLS - 1)) >> CELL_AW;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        last_addr_next = last_addr_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        issue_next     = '0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    case (item.mode)
                        MODE_LOAD:
                        begin
                            if (wr.en)
                            begin
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        MODE_QUERY:
                        begin
                            q_next.x   = item.x_index;
                            q_next.y   = item.y_index;
                            q_next.z   = item.z_index;
                            addr_next  = '0;
                            acc_next   = 1'b0;
                            state_next = ST_SWEEP;
                            if (words == '0)
                            begin
                                last_addr_next = '0;
                            end
                            else
                            begin
                                last_addr_next = BANK_AW'(words - COUNT_W'(1));
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                issue_next.valid = 1'b1;
                issue_next.last  = (addr_reg == last_addr_reg);
                issue_next.addr  = addr_reg;
                issue_next.q     = q_reg;
                issue_next.hit   = 1'b0;
                addr_next        = addr_reg + BANK_AW'(1);
                // On a long sweep the first words leave the chain before the last enters.
                if (chain[NUM_CELLS].valid)
                begin
                    acc_next = acc_reg || chain[NUM_CELLS].hit;
                end
                if (addr_reg == last_addr_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (chain[NUM_CELLS].valid)
                begin
                    acc_next = acc_reg || chain[NUM_CELLS].hit;
                    if (chain[NUM_CELLS].last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            last_addr_reg <= '0;
            acc_reg       <= 1'b0;
            issue_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            last_addr_reg <= last_addr_next;
            acc_reg       <= acc_next;
            issue_reg     <= issue_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (out_load)
        begin
            out_label_reg <= acc_reg;
            out_q_reg     <= q_reg;
        end
    end

    // The chain: each cell tests its bank entry and hands the word to the next cell.
    assign chain[0] = issue_reg;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        vrnl_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_id  (CELL_AW'(k)),
            .count    (count_reg),
            .geom     (geom),
            .wr       (wr),
            .word_in  (chain[k]),
            .word_out (chain[k+1])
        );
    end

    assign result.valid      = out_valid_reg;
    assign result.near_label = out_label_reg;
    assign result.echo_x     = out_q_reg.x;
    assign result.echo_y     = out_q_reg.y;
    assign result.echo_z     = out_q_reg.z;

endmodule

`default_nettype wire

// File: rtl/vrnl_cell.sv
// One cell of the chain: a bank of reference voxels and a distance test pipeline.
`default_nettype none

module vrnl_cell
    import vrnl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CELL_AW-1:0] cell_id,
    input  wire logic [COUNT_W-1:0] count,
    input  wire vrnl_geom_t         geom,
    input  wire vrnl_wr_t           wr,
    input  wire vrnl_word_t         word_in,
    output      vrnl_word_t         word_out
);

    vrnl_point_t bank [BANK_DEPTH];

    vrnl_point_t        rd_reg;
    vrnl_word_t         w1_reg, w2_reg, w3_reg, w4_reg, w5_reg, out_reg;
    vrnl_word_t         out_next;
    logic               en1_reg, en2_reg, en3_reg, en4_reg, en5_reg;
    logic               en1_next;
    logic [COORD_BITS-1:0] dx_next, dy_next, dz_next;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, dz_reg;
    logic [LEN_W-1:0]   len_x_reg, len_y_reg, len_z_reg;
    logic [SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [SQ_W-1:0]    limit_ext;
    logic               over_next, over_reg;
    logic [SUM_W-1:0]   sum_xy_reg;
    logic [SQ_W-1:0]    sq_z5_reg;
    logic [SUM_W-1:0]   total;
    logic               hit_next;

    // Reference i lives in cell (i mod NUM_CELLS) at address (i / NUM_CELLS).
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.lane == cell_id))
        begin
            bank[wr.addr] <= wr.data;
        end
        rd_reg <= bank[word_in.addr];
    end

    assign en1_next = word_in.valid &&
                      (COUNT_W'({word_in.addr, cell_id}) < count);

    assign dx_next = (rd_reg.x >= w1_reg.q.x) ? rd_reg.x - w1_reg.q.x : w1_reg.q.x - rd_reg.x;
    assign dy_next = (rd_reg.y >= w1_reg.q.y) ? rd_reg.y - w1_reg.q.y : w1_reg.q.y - rd_reg.y;
    assign dz_next = (rd_reg.z >= w1_reg.q.z) ? rd_reg.z - w1_reg.q.z : w1_reg.q.z - rd_reg.z;

    assign limit_ext = SQ_W'(geom.limit);
    assign over_next = (sq_x_reg > limit_ext) || (sq_y_reg > limit_ext) ||
                       (sq_z_reg > limit_ext);

    assign total    = sum_xy_reg + SUM_W'(sq_z5_reg);
    assign hit_next = w5_reg.hit ||
                      (en5_reg && !over_reg && (total <= SUM_W'(geom.limit)));

    always_comb
    begin
        out_next     = w5_reg;
        out_next.hit = hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w1_reg  <= '0;
            w2_reg  <= '0;
            w3_reg  <= '0;
            w4_reg  <= '0;
            w5_reg  <= '0;
            out_reg <= '0;
            en1_reg <= 1'b0;
            en2_reg <= 1'b0;
            en3_reg <= 1'b0;
            en4_reg <= 1'b0;
            en5_reg <= 1'b0;
        end
        else
        begin
            w1_reg  <= word_in;
            en1_reg <= en1_next;
            w2_reg  <= w1_reg;
            en2_reg <= en1_reg;
            w3_reg  <= w2_reg;
            en3_reg <= en2_reg;
            w4_reg  <= w3_reg;
            en4_reg <= en3_reg;
            w5_reg  <= w4_reg;
            en5_reg <= en4_reg;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        dz_reg     <= dz_next;
        len_x_reg  <= LEN_W'(dx_reg) * LEN_W'(geom.pitch_x);
        len_y_reg  <= LEN_W'(dy_reg) * LEN_W'(geom.pitch_y);
        len_z_reg  <= LEN_W'(dz_reg) * LEN_W'(geom.pitch_z);
        sq_x_reg   <= SQ_W'(len_x_reg) * SQ_W'(len_x_reg);
        sq_y_reg   <= SQ_W'(len_y_reg) * SQ_W'(len_y_reg);
        sq_z_reg   <= SQ_W'(len_z_reg) * SQ_W'(len_z_reg);
        over_reg   <= over_next;
        sum_xy_reg <= SUM_W'(sq_x_reg) + SUM_W'(sq_y_reg);
        sq_z5_reg  <= sq_z_reg;
    end

    assign word_out = out_reg;

endmodule

`default_nettype wire

// File: rtl/vrnl_checker.sv
// Port-level assertions for the voxel radius neighbor labeller and their bind.
`default_nettype none

module vrnl_checker
    import vrnl_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  item_valid,
    input wire logic                  item_ready,
    input wire logic [MODE_W-1:0]     item_mode,
    input wire logic [COORD_BITS-1:0] item_x,
    input wire logic [COORD_BITS-1:0] item_y,
    input wire logic [COORD_BITS-1:0] item_z,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic [COORD_BITS-1:0] result_echo_x,
    input wire logic [COORD_BITS-1:0] result_echo_y,
    input wire logic [COORD_BITS-1:0] result_echo_z
);

    logic                  query_acc;
    logic                  result_acc;
    logic [1:0]            pending_reg;
    logic [COORD_BITS-1:0] last_x_reg, last_y_reg, last_z_reg;

    assign query_acc  = item_valid && item_ready && (item_mode == MODE_QUERY);
    assign result_acc = result_valid && result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(query_acc) - 2'(result_acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            last_x_reg <= item_x;
            last_y_reg <= item_y;
            last_z_reg <= item_z;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> result_valid)
        else $error("result word dropped while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pending_reg != 2'd0))
        else $error("result word without an outstanding query");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> !item_ready)
        else $error("input taken while a query sweep starts");

    a_echo_match: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (pending_reg == 2'd1)) |->
        ((result_echo_x == last_x_reg) && (result_echo_y == last_y_reg) &&
         (result_echo_z == last_z_reg)))
        else $error("result echo differs from the outstanding query");

endmodule

bind voxel_radius_neighbor_label_core vrnl_checker u_vrnl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .item_mode     (item.mode),
    .item_x        (item.x_index),
    .item_y        (item.y_index),
    .item_z        (item.z_index),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_echo_x (result.echo_x),
    .result_echo_y (result.echo_y),
    .result_echo_z (result.echo_z)
);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the voxel radius neighbor labeller, with its own label predictor.

module testbench;
    import vrnl_pkg::*;

    // The fourth mode code has no meaning; such words must be swallowed without effect.
    localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    // A full store takes 128 sweep words plus the pass through the chain and control, so the
    // settle time covers any word still in flight once the last result has come out.
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_WORDS   = 130;
    localparam int FULL_PHASE    = 2;
    localparam int HOLD_PHASE    = 3;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int NUM_DIRECTED  = 24;

    // One result the block owes us: the label and the echoed query indices.
    typedef struct {
        logic                  near;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } label_word_t;

    // One row of the directed table. When fixed is set the label is typed in here,
    // otherwise it comes from the predictor.
    typedef struct {
        logic [MODE_W-1:0]     mode;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
        bit                    fixed;
        logic                  near;
    } directed_word_t;

    logic clk;
    logic rst_n;

    vrnl_item_if   item_ch ();
    vrnl_result_if result_ch ();
    vrnl_cfg_if    cfg_ch ();

    voxel_radius_neighbor_label_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (result_ch)
    );

    // Predictor state: the stored voxels, how many there are, and the geometry.
    vrnl_point_t        stored_voxel [MAX_POINTS];
    int unsigned        stored_count;
    logic [PITCH_W-1:0] pitch_x;
    logic [PITCH_W-1:0] pitch_y;
    logic [PITCH_W-1:0] pitch_z;
    logic [THR_W-1:0]   near_radius;

    label_word_t awaited_labels [$];
    int unsigned error_count;
    int          quiet_cycles;
    bit          hold_request;
    int          tx_gap_max;
    int          rx_gap_max;

    // Directed part, run with the reset geometry: unit pitch on every axis and a
    // threshold of exactly one voxel, so a query is near only when it sits on a stored
    // voxel or one step away along a single axis.
    directed_word_t directed_words [NUM_DIRECTED] = '{
        // Empty store right after reset labels far.
        '{MODE_QUERY,   10'd0,    10'd0,    10'd0,    1'b1, 1'b0},
        // An unused mode code with all index bits set must not load anything.
        '{MODE_IGNORED, 10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0},
        '{MODE_QUERY,   10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0},
        '{MODE_LOAD,    10'd0,    10'd0,    10'd0,    1'b0, 1'b0},
        '{MODE_QUERY,   10'd0,    10'd0,    10'd0,    1'b1, 1'b1},
        // A distance exactly equal to the threshold still counts as near.
        '{MODE_QUERY,   10'd1,    10'd0,    10'd0,    1'b1, 1'b1},
        '{MODE_QUERY,   10'd0,    10'd0,    10'd1,    1'b1, 1'b1},
        // The diagonal neighbor is root two away and therefore far.
        '{MODE_QUERY,   10'd1,    10'd1,    10'd0,    1'b1, 1'b0},
        '{MODE_QUERY,   10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b0},
        '{MODE_LOAD,    10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0},
        '{MODE_QUERY,   10'd1023, 10'd1023, 10'd1022, 1'b1, 1'b1},
        '{MODE_QUERY,   10'd0,    10'd1023, 10'd0,    1'b1, 1'b0},
        // After a clear the store is empty again.
        '{MODE_CLEAR,   10'd0,    10'd0,    10'd0,    1'b0, 1'b0},
        '{MODE_QUERY,   10'd0,    10'd0,    10'd0,    1'b1, 1'b0},
        '{MODE_LOAD,    10'd341,  10'd682,  10'd341,  1'b0, 1'b0},
        '{MODE_LOAD,    10'd682,  10'd341,  10'd682,  1'b0, 1'b0},
        '{MODE_QUERY,   10'd341,  10'd682,  10'd342,  1'b0, 1'b0},
        '{MODE_QUERY,   10'd682,  10'd341,  10'd681,  1'b0, 1'b0},
        '{MODE_IGNORED, 10'd0,    10'd0,    10'd0,    1'b0, 1'b0},
        '{MODE_QUERY,   10'd500,  10'd500,  10'd500,  1'b1, 1'b0},
        '{MODE_CLEAR,   10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b0},
        '{MODE_QUERY,   10'd682,  10'd341,  10'd682,  1'b1, 1'b0},
        '{MODE_LOAD,    10'd2,    10'd0,    10'd0,    1'b0, 1'b0},
        '{MODE_QUERY,   10'd0,    10'd0,    10'd0,    1'b0, 1'b0}
    };

    // Square of one pitch-scaled axis distance, in Q.16 units.
    function automatic longint unsigned axis_square(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b,
                                                    input logic [PITCH_W-1:0] pitch);
        longint unsigned d;
        longint unsigned len;
        d = (a >= b) ? a - b : b - a;
        len = d * pitch;
        return len * len;
    endfunction

    // A query is near when any stored voxel lies within the squared threshold. The sum
    // of three squares stays below 2^54, so 64 bits hold it exactly.
    function automatic logic predict_near(input vrnl_point_t q);
        longint unsigned limit;
        longint unsigned tx;
        longint unsigned ty;
        longint unsigned tz;
        limit = near_radius;
        limit = limit * limit;
        for (int i = 0; i < stored_count; i++)
        begin
            tx = axis_square(stored_voxel[i].x, q.x, pitch_x);
            ty = axis_square(stored_voxel[i].y, q.y, pitch_y);
            tz = axis_square(stored_voxel[i].z, q.z, pitch_z);
            if (tx <= limit && ty <= limit && tz <= limit && tx + ty + tz <= limit)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Update the predictor for a word the block has just accepted.
    function automatic void note_word(input logic [MODE_W-1:0] mode, input vrnl_point_t q,
                                      input bit fixed, input logic typed_near);
        label_word_t w;
        case (mode)
            MODE_LOAD:
            begin
                // Loads beyond capacity are dropped.
                if (stored_count < MAX_POINTS)
                begin
                    stored_voxel[stored_count] = q;
                    stored_count++;
                end
            end
            MODE_CLEAR:
                stored_count = 0;
            MODE_QUERY:
            begin
                w.near = fixed ? typed_near : predict_near(q);
                w.x = q.x;
                w.y = q.y;
                w.z = q.z;
                awaited_labels = {awaited_labels, w};
            end
            default:
                ;
        endcase
    endfunction

    // Offer one word after a random gap and hold it until the block takes it. Valid is
    // left high afterwards so back-to-back words never drop it in between.
    task automatic send_word(input logic [MODE_W-1:0] mode, input vrnl_point_t q,
                             input bit fixed, input logic typed_near);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= mode;
        item_ch.x_index <= q.x;
        item_ch.y_index <= q.y;
        item_ch.z_index <= q.z;
        do @(posedge clk); while (!item_ch.ready);
        note_word(mode, q, fixed, typed_near);
    endtask

    // Stop offering words, let every owed result come out, then give loads and clears
    // that trail the last query time to finish.
    task automatic wait_until_idle();
        item_ch.valid <= 1'b0;
        while (awaited_labels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (index)
            REG_PITCH_X:   pitch_x = value[PITCH_W-1:0];
            REG_PITCH_Y:   pitch_y = value[PITCH_W-1:0];
            REG_PITCH_Z:   pitch_z = value[PITCH_W-1:0];
            REG_THRESHOLD: near_radius = value[THR_W-1:0];
            default:       ;
        endcase
    endtask

    task automatic configure(input logic [PITCH_W-1:0] px, input logic [PITCH_W-1:0] py,
                             input logic [PITCH_W-1:0] pz, input logic [THR_W-1:0] thr);
        wait_until_idle();
        write_register(REG_PITCH_X, CFG_DATA_W'(px));
        write_register(REG_PITCH_Y, CFG_DATA_W'(py));
        write_register(REG_PITCH_Z, CFG_DATA_W'(pz));
        write_register(REG_THRESHOLD, CFG_DATA_W'(thr));
        cfg_ch.valid <= 1'b0;
    endtask

    // An index scattered around a center, clamped to the grid.
    function automatic logic [COORD_BITS-1:0] near_coord(input int center, input int spread);
        int v;
        v = center - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_BITS-1:0];
    endfunction

    // Mostly loads and queries clustered around one spot so both labels occur, with
    // some clears, unused mode codes and words spread over the whole grid.
    task automatic run_random_phase(input int words, input bit with_hold);
        int          center_x;
        int          center_y;
        int          center_z;
        int          spread;
        int          pick;
        vrnl_point_t q;
        center_x = $urandom_range(0, COORD_MAX);
        center_y = $urandom_range(0, COORD_MAX);
        center_z = $urandom_range(0, COORD_MAX);
        spread   = $urandom_range(1, 6);
        for (int n = 0; n < words; n++)
        begin
            // Part way in, the result side backs off for a long stretch while words
            // keep coming, so the block fills up and has to stall its input.
            if (with_hold && n == 20)
                hold_request = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 86)
            begin
                q.x = near_coord(center_x, spread);
                q.y = near_coord(center_y, spread);
                q.z = near_coord(center_z, spread);
            end
            else
            begin
                q.x = COORD_BITS'($urandom_range(0, COORD_MAX));
                q.y = COORD_BITS'($urandom_range(0, COORD_MAX));
                q.z = COORD_BITS'($urandom_range(0, COORD_MAX));
            end
            if (pick < 30 || (pick >= 94 && pick < 97))
                send_word(MODE_LOAD, q, 1'b0, 1'b0);
            else if (pick < 86 || pick >= 97)
                send_word(MODE_QUERY, q, 1'b0, 1'b0);
            else if (pick < 90)
                send_word(MODE_CLEAR, q, 1'b0, 1'b0);
            else
                send_word(MODE_IGNORED, q, 1'b0, 1'b0);
        end
    endtask

    // Fill the store to capacity, try a few more loads that must be dropped, then query
    // around the stored voxels. Stored voxels keep x in the lower half of the grid, so a
    // query at the far corner only hits if a dropped load slipped in.
    task automatic fill_store();
        vrnl_point_t q;
        send_word(MODE_CLEAR, '0, 1'b0, 1'b0);
        for (int n = 0; n < MAX_POINTS; n++)
        begin
            q.x = COORD_BITS'($urandom_range(0, COORD_MAX / 2));
            q.y = COORD_BITS'($urandom_range(0, COORD_MAX));
            q.z = COORD_BITS'($urandom_range(0, COORD_MAX));
            send_word(MODE_LOAD, q, 1'b0, 1'b0);
        end
        q = '1;
        repeat (3) send_word(MODE_LOAD, q, 1'b0, 1'b0);
        send_word(MODE_QUERY, q, 1'b0, 1'b0);
        for (int n = 0; n < 30; n++)
        begin
            // One step along z stays near; two steps along y is far.
            q = stored_voxel[$urandom_range(0, MAX_POINTS - 1)];
            if (q.z != COORD_MAX[COORD_BITS-1:0])
                q.z = q.z + COORD_BITS'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
                q.y[1] = ~q.y[1];
            send_word(MODE_QUERY, q, 1'b0, 1'b0);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Result side: a random stall before each word, plus the one long hold-off.
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = $urandom_range(0, rx_gap_max);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Every result word is matched against the oldest label still owed.
    always @(posedge clk)
    begin
        label_word_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (awaited_labels.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got label %0d at (%0d,%0d,%0d)",
                         $time, result_ch.near_label, result_ch.echo_x, result_ch.echo_y,
                         result_ch.echo_z);
                error_count++;
            end
            else
            begin
                want = awaited_labels.pop_front();
                check_field("near_label", want.near, result_ch.near_label);
                check_field("echo_x", want.x, result_ch.echo_x);
                check_field("echo_y", want.y, result_ch.echo_y);
                check_field("echo_z", want.z, result_ch.echo_z);
            end
        end
    end

    // Watchdog: too long without any word moving on any channel means a hang.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        vrnl_point_t q;
        int          px;
        int          py;
        int          pz;
        int          thr;
        rst_n           <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.mode    <= MODE_LOAD;
        item_ch.x_index <= '0;
        item_ch.y_index <= '0;
        item_ch.z_index <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= REG_PITCH_X;
        cfg_ch.data     <= '0;
        pitch_x      = PITCH_RESET;
        pitch_y      = PITCH_RESET;
        pitch_z      = PITCH_RESET;
        near_radius  = THR_RESET;
        stored_count = 0;
        error_count  = 0;
        quiet_cycles = 0;
        hold_request = 1'b0;
        tx_gap_max   = 5;
        rx_gap_max   = 5;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
        begin
            q.x = directed_words[i].x;
            q.y = directed_words[i].y;
            q.z = directed_words[i].z;
            send_word(directed_words[i].mode, q, directed_words[i].fixed,
                      directed_words[i].near);
        end

        // Each phase sets a new geometry while the block is idle. Some phases run one
        // side or the other without any idle cycles.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            tx_gap_max = (p % 3 == 1) ? 0 : 5;
            rx_gap_max = (p % 3 == 2) ? 0 : 5;
            case (p)
                0:
                    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
                1:
                    // Zero pitch on x makes that axis irrelevant; a zero threshold
                    // only accepts exact matches on the other axes.
                    configure(16'd0, 16'd1, 16'hFFFF, 24'd0);
                FULL_PHASE:
                    configure(PITCH_RESET, PITCH_RESET, PITCH_RESET, THR_RESET);
                default:
                begin
                    // Threshold a few voxel pitches long, so near and far both show up.
                    px  = $urandom_range(1, 2048);
                    py  = $urandom_range(1, 2048);
                    pz  = $urandom_range(1, 2048);
                    thr = px * $urandom_range(0, 4) + $urandom_range(0, 255);
                    configure(px[PITCH_W-1:0], py[PITCH_W-1:0], pz[PITCH_W-1:0],
                              thr[THR_W-1:0]);
                end
            endcase
            if (p == FULL_PHASE)
                fill_store();
            else
                run_random_phase(PHASE_WORDS, p == HOLD_PHASE);
        end

        wait_until_idle();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
